/* src/windowed_contact_rate_ema_defines.svh */
// Assertion macros shared by the windowed contact-rate EMA modules.
`ifndef WINDOWED_CONTACT_RATE_EMA_DEFINES_SVH
`define WINDOWED_CONTACT_RATE_EMA_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WCRE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WCRE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wcre_pkg.sv */
// Package: types, constants and controller/datapath interface structs.
`default_nettype none
package wcre_pkg;

    // Default parameter values
    localparam int NODES_DEF      = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // Fixed field widths
    localparam int ALPHA_W    = 17;
    localparam int WS_W       = 32;
    localparam int NODE_AVG_W = 32;
    localparam int TOTAL_W    = 38;
    localparam int OP_W       = 2;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 16;

    localparam logic [ALPHA_W-1:0]    ONE_Q16   = 17'h10000;
    localparam logic [ALPHA_W-1:0]    ALPHA_RST = 17'd6554;
    localparam logic [WS_W-1:0]       WS_RST    = 32'd1000;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
    localparam logic [NODE_AVG_W-1:0] NODE_MAX  = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b1;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_UP    = 2'd0,
        OP_DOWN  = 2'd1,
        OP_NODE  = 2'd2,
        OP_TOTAL = 2'd3
    } op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic div_load;   // latch item, start divide
        logic div_step;   // one quotient bit
        logic err_set;    // window went backwards
        logic load_rest;  // extra decay passes, clear total sum
        logic sel_total;  // blend works on the total average
        logic mul_m1;     // acc = keep*avg >> 16
        logic mul_m2;     // v = sat(acc + alpha*count)
        logic dec_step;   // v = keep*v >> 16, one pass used
        logic sw_write;   // write node average, clear count
        logic tot_write;  // write total average, advance window
        logic clr_write;  // zero one entry after reset
        logic addr_idx;   // address memories by the item's node
        logic op_write;   // apply the operation to the count
        logic load_result;// load the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic win_lt;
        logic win_gt;
        logic dec_stop;
    } stat_t;

endpackage
`default_nettype wire

/* src/wcre_dp.sv */
// Datapath: divider, node tables, shared blend/decay multiplier, result register.
`default_nettype none
`include "windowed_contact_rate_ema_defines.svh"
module wcre_dp #(
    parameter int NODES      = wcre_pkg::NODES_DEF,
    parameter int COUNT_BITS = wcre_pkg::COUNT_BITS_DEF,
    parameter int TIME_BITS  = wcre_pkg::TIME_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [wcre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wcre_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [wcre_pkg::OP_W-1:0]       operation,
    input  wire logic [wcre_pkg::IDX_W-1:0]      node_index,
    input  wire logic [TIME_BITS-1:0]            current_time,
    input  wire wcre_pkg::cmd_t                  cmd,
    input  wire logic [$clog2(NODES)-1:0]        node_addr,
    output wcre_pkg::stat_t                      stat,
    output logic [wcre_pkg::NODE_AVG_W-1:0]      node_rate,
    output logic [wcre_pkg::TOTAL_W-1:0]         total_rate,
    output logic                                 time_error
);
    import wcre_pkg::*;

    localparam int NODE_W  = $clog2(NODES);
    localparam int SUM_W   = COUNT_BITS + $clog2(NODES);
    localparam int MUL_Y_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int PROD_W  = ALPHA_W + MUL_Y_W;
    localparam int ACC_W   = PROD_W - FRAC_BITS;
    localparam int DCNT_W  = $clog2(TIME_BITS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [WS_W-1:0]    ws_reg;

    // Item
    logic [OP_W-1:0]  op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             err_reg;
    logic             idx_ok;

    // Divider
    logic [TIME_BITS-1:0] q_reg, q_next;
    logic [WS_W-1:0]      rem_reg, rem_next;
    logic [DCNT_W-1:0]    dcnt_reg;
    logic [WS_W-1:0]      ws_eff;
    logic [WS_W:0]        rem_sh;

    // Window and sweep state
    logic [TIME_BITS-1:0] last_reg;
    logic [TIME_BITS-1:0] rest_reg;
    logic [TIME_BITS-1:0] pass_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [SUM_W-1:0]     sum_reg;

    // Tables
    logic [COUNT_BITS-1:0] count_mem [NODES];
    logic [NODE_AVG_W-1:0] avg_mem   [NODES];
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [NODE_AVG_W-1:0] rd_avg_reg;
    logic [NODE_W-1:0]     mem_addr;
    logic                  cnt_we, avg_we;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [NODE_AVG_W-1:0] avg_wdata;

    // Arithmetic
    logic [ALPHA_W-1:0] a_eff, keep;
    logic [ALPHA_W-1:0] mul_x;
    logic [MUL_Y_W-1:0] mul_y, avg_src, cnt_src;
    logic [PROD_W-1:0]  product;
    logic [ACC_W-1:0]   acc_reg;
    logic [PROD_W:0]    blend, cap;
    logic [TOTAL_W-1:0] v_reg, nv;

    // Output register
    logic [NODE_AVG_W-1:0] node_rate_reg;
    logic [TOTAL_W-1:0]    total_rate_reg;
    logic                  time_error_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            ws_reg    <= WS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA:       alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_WINDOW_SIZE: ws_reg    <= cfg_data[WS_W-1:0];
                default:         ;
            endcase
        end
    end

    assign a_eff  = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
    assign keep   = ONE_Q16 - a_eff;
    assign ws_eff = (ws_reg == '0) ? WS_W'(1) : ws_reg;
    assign idx_ok = (32'(idx_reg) < 32'(NODES));

    // Restoring divider, one quotient bit per step
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[TIME_BITS-1]};
        rem_next = rem_sh[WS_W-1:0];
        q_next   = {q_reg[TIME_BITS-2:0], 1'b0};
        if (rem_sh >= {1'b0, ws_eff})
        begin
            rem_next  = WS_W'(rem_sh - {1'b0, ws_eff});
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (cmd.div_load)
        begin
            dcnt_reg <= DCNT_W'(TIME_BITS);
            err_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.div_step)
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            if (cmd.err_set)
                err_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            q_reg   <= current_time;
            rem_reg <= '0;
            op_reg  <= operation;
            idx_reg <= node_index;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    // Shared multiplier
    always_comb
    begin
        avg_src = cmd.sel_total ? MUL_Y_W'(total_reg) : MUL_Y_W'(rd_avg_reg);
        cnt_src = cmd.sel_total ? MUL_Y_W'(sum_reg) : MUL_Y_W'(rd_cnt_reg);
        mul_x   = cmd.mul_m2 ? a_eff : keep;
        if (cmd.mul_m2)
            mul_y = cnt_src;
        else if (cmd.mul_m1)
            mul_y = avg_src;
        else
            mul_y = MUL_Y_W'(v_reg);
        product = PROD_W'(mul_x) * PROD_W'(mul_y);
        blend   = (PROD_W + 1)'(acc_reg) + (PROD_W + 1)'(product);
        cap     = cmd.sel_total ? (PROD_W + 1)'(TOTAL_MAX) : (PROD_W + 1)'(NODE_MAX);
        nv      = TOTAL_W'(product >> FRAC_BITS);
    end

    // Blend and decay registers; each entry starts with the full count of extra passes
    always_ff @(posedge clk)
    begin
        if (cmd.mul_m1)
            acc_reg <= product[PROD_W-1:FRAC_BITS];
        if (cmd.mul_m2)
        begin
            v_reg    <= (blend > cap) ? TOTAL_W'(cap) : TOTAL_W'(blend);
            pass_reg <= rest_reg;
        end
        else if (cmd.dec_step)
        begin
            v_reg    <= nv;
            pass_reg <= pass_reg - TIME_BITS'(1);
        end
        if (cmd.load_rest)
        begin
            rest_reg <= q_reg - last_reg - TIME_BITS'(1);
            sum_reg  <= '0;
        end
        else if (cmd.sw_write)
            sum_reg <= sum_reg + SUM_W'(rd_cnt_reg);
    end

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            last_reg  <= '0;
        end
        else if (cmd.tot_write)
        begin
            total_reg <= v_reg;
            last_reg  <= q_reg;
        end
    end

    // Tables: one write and one registered read per cycle
    always_comb
    begin
        mem_addr  = cmd.addr_idx ? NODE_W'(idx_reg) : node_addr;
        cnt_we    = cmd.clr_write || cmd.sw_write
                    || (cmd.op_write && (op_reg == OP_UP) && idx_ok && !err_reg
                        && (rd_cnt_reg != COUNT_MAX));
        avg_we    = cmd.clr_write || cmd.sw_write;
        cnt_wdata = cmd.op_write ? rd_cnt_reg + COUNT_BITS'(1) : '0;
        avg_wdata = cmd.clr_write ? '0 : v_reg[NODE_AVG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            count_mem[mem_addr] <= cnt_wdata;
        if (avg_we)
            avg_mem[mem_addr] <= avg_wdata;
        rd_cnt_reg <= count_mem[mem_addr];
        rd_avg_reg <= avg_mem[mem_addr];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            node_rate_reg  <= idx_ok ? rd_avg_reg : '0;
            total_rate_reg <= total_reg;
            time_error_reg <= err_reg;
        end
    end

    assign stat.div_done = (dcnt_reg == '0);
    assign stat.win_lt   = (q_reg < last_reg);
    assign stat.win_gt   = (q_reg > last_reg);
    assign stat.dec_stop = (pass_reg == '0) || (v_reg == '0) || (nv == v_reg);

    assign node_rate  = node_rate_reg;
    assign total_rate = total_rate_reg;
    assign time_error = time_error_reg;

    `WCRE_ASSERT_NXT(a_decay_shrinks, cmd.dec_step, v_reg < $past(v_reg), "decay pass did not shrink")
    `WCRE_ASSERT_NXT(a_load_clears_err, cmd.div_load, !err_reg, "error flag survived new item")
    `WCRE_ASSERT_NXT(a_window_caught_up, cmd.tot_write, !stat.win_gt && !stat.win_lt, "window not advanced")

endmodule
`default_nettype wire

/* src/wcre_ctrl.sv */
// Controller: sequences clear, divide, window sweep, count update and result.
`default_nettype none
`include "windowed_contact_rate_ema_defines.svh"
module wcre_ctrl #(
    parameter int NODES = wcre_pkg::NODES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    input  wire wcre_pkg::stat_t          stat,
    output wcre_pkg::cmd_t                cmd,
    output logic [$clog2(NODES)-1:0]      node_addr
);
    import wcre_pkg::*;

    localparam int NODE_W = $clog2(NODES);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_DIV    = 12'b0000_0000_0100,
        S_CHECK  = 12'b0000_0000_1000,
        S_SW_RD  = 12'b0000_0001_0000,
        S_SW_M1  = 12'b0000_0010_0000,
        S_SW_M2  = 12'b0000_0100_0000,
        S_SW_DEC = 12'b0000_1000_0000,
        S_SW_WR  = 12'b0001_0000_0000,
        S_OP_RD  = 12'b0010_0000_0000,
        S_OP_WR  = 12'b0100_0000_0000,
        S_RESP   = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              tot_reg, tot_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_node, out_free;

    assign last_node = (node_reg == NODE_W'(NODES - 1));
    assign out_free  = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        tot_next       = tot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sel_total  = tot_reg;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                node_next     = node_reg + NODE_W'(1);
                if (last_node)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_CHECK;
                else
                    cmd.div_step = 1'b1;
            end
            S_CHECK:
            begin
                priority if (stat.win_lt)
                begin
                    cmd.err_set = 1'b1;
                    state_next  = S_OP_RD;
                end
                else if (stat.win_gt)
                begin
                    cmd.load_rest = 1'b1;
                    node_next     = '0;
                    tot_next      = 1'b0;
                    state_next    = S_SW_RD;
                end
                else
                    state_next = S_OP_RD;
            end
            S_SW_RD:  state_next = S_SW_M1;
            S_SW_M1:
            begin
                cmd.mul_m1 = 1'b1;
                state_next = S_SW_M2;
            end
            S_SW_M2:
            begin
                cmd.mul_m2 = 1'b1;
                state_next = S_SW_DEC;
            end
            S_SW_DEC:
            begin
                if (stat.dec_stop)
                    state_next = S_SW_WR;
                else
                    cmd.dec_step = 1'b1;
            end
            S_SW_WR:
            begin
                priority if (tot_reg)
                begin
                    cmd.tot_write = 1'b1;
                    tot_next      = 1'b0;
                    state_next    = S_OP_RD;
                end
                else if (last_node)
                begin
                    cmd.sw_write = 1'b1;
                    tot_next     = 1'b1;
                    state_next   = S_SW_M1;
                end
                else
                begin
                    cmd.sw_write = 1'b1;
                    node_next    = node_reg + NODE_W'(1);
                    state_next   = S_SW_RD;
                end
            end
            S_OP_RD:
            begin
                cmd.addr_idx = 1'b1;
                state_next   = S_OP_WR;
            end
            S_OP_WR:
            begin
                cmd.addr_idx = 1'b1;
                cmd.op_write = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                cmd.addr_idx = 1'b1;
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            node_reg      <= '0;
            tot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            tot_reg       <= tot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign node_addr = node_reg;
    assign out_valid = out_valid_reg;

    `WCRE_ASSERT_NXT(a_resp_beat, (state_reg == S_RESP) && out_free, out_valid_reg && (state_reg == S_IDLE), "result beat not presented")
    `WCRE_ASSERT_NXT(a_sweep_to_total, (state_reg == S_SW_WR) && !tot_reg && last_node, (state_reg == S_SW_M1) && tot_reg, "total update skipped")
    `WCRE_ASSERT_NXT(a_err_skips_sweep, (state_reg == S_CHECK) && stat.win_lt, state_reg == S_OP_RD, "backward window swept")

endmodule
`default_nettype wire

/* src/windowed_contact_rate_ema.sv */
// Top level: windowed contact-rate moving average with per-node and total EMA.
//
// Input channel (in_valid/in_ready) takes one beat: operation, node_index and
// current_time. Output channel (out_valid/out_ready) returns one beat per input:
// node_rate (Q16.16), total_rate (Q22.16) and time_error.
// cfg_we/cfg_index/cfg_data write alpha (index 0) and window_size (index 1);
// write only while the block is idle.
// When the window does not move, the serial divider yields one quotient bit per
// cycle, then the count is updated and the result loaded; the next beat can be
// taken in the cycle after that. When windows are crossed, a sweep over all NODES
// entries reads, blends, decays (up to one pass per extra window) and writes each
// entry, then blends, decays and writes the total.
// One item is in work at a time; the next beat is taken once the result is in
// the output register, even if the receiver has not taken it yet.
// Reset: a clearing pass over all NODES entries zeroes both node tables; in_ready is
// low during it. A stalled receiver holds the result; the block then stalls
// at the end of the following item.
`default_nettype none
module windowed_contact_rate_ema #(
    parameter int NODES      = wcre_pkg::NODES_DEF,
    parameter int COUNT_BITS = wcre_pkg::COUNT_BITS_DEF,
    parameter int TIME_BITS  = wcre_pkg::TIME_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [wcre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wcre_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [wcre_pkg::OP_W-1:0]       operation,
    input  wire logic [wcre_pkg::IDX_W-1:0]      node_index,
    input  wire logic [TIME_BITS-1:0]            current_time,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [wcre_pkg::NODE_AVG_W-1:0]      node_rate,
    output logic [wcre_pkg::TOTAL_W-1:0]         total_rate,
    output logic                                 time_error
);
    import wcre_pkg::*;

    cmd_t                     cmd;
    stat_t                    stat;
    logic [$clog2(NODES)-1:0] node_addr;

    // Sequencer
    wcre_ctrl #(
        .NODES(NODES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd),
        .node_addr(node_addr)
    );

    // Arithmetic and tables
    wcre_dp #(
        .NODES     (NODES),
        .COUNT_BITS(COUNT_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .node_index  (node_index),
        .current_time(current_time),
        .cmd         (cmd),
        .node_addr   (node_addr),
        .stat        (stat),
        .node_rate   (node_rate),
        .total_rate  (total_rate),
        .time_error  (time_error)
    );

endmodule
`default_nettype wire
